>>> hw/rtl/ssnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared types, constants and the digit-to-segment table of the formatter.
// ----------------------------------------------------------------------------
package ssnf_pkg;

    localparam int SEG_W      = 7;
    localparam int MAX_DIGITS = 8;
    localparam int SEGS_W     = SEG_W * MAX_DIGITS;

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    localparam logic [6:0]  SEG_MINUS   = 7'h40;
    localparam logic [31:0] DEC_MAX     = 32'd99999999;
    localparam logic [31:0] DEC_MIN_MAG = 32'd9999999;
    // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
    localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;

    typedef struct packed {
        logic              valid;
        logic              op;
        logic [31:0]       val;
        logic [3:0]        dots;
        logic [3:0]        hex_cnt;
        logic              neg;
        logic              done;
        logic              rejected;
        logic [SEGS_W-1:0] segments;
    } t_cell_st;

    function automatic logic [6:0] seg_code(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'h0:    c = 7'h3F;
            4'h1:    c = 7'h06;
            4'h2:    c = 7'h5B;
            4'h3:    c = 7'h4F;
            4'h4:    c = 7'h66;
            4'h5:    c = 7'h6D;
            4'h6:    c = 7'h7D;
            4'h7:    c = 7'h07;
            4'h8:    c = 7'h7F;
            4'h9:    c = 7'h6F;
            4'hA:    c = 7'h77;
            4'hB:    c = 7'h7C;
            4'hC:    c = 7'h39;
            4'hD:    c = 7'h5E;
            4'hE:    c = 7'h79;
            default: c = 7'h71;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ssnf_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_req_if
// Request channel: display mode, value and formatting controls.
// ----------------------------------------------------------------------------
interface ssnf_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] value_bits;
    logic [3:0]  dots;
    logic [3:0]  hex_count;

    modport source (output valid, op, value_bits, dots, hex_count, input ready);
    modport sink   (input valid, op, value_bits, dots, hex_count, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ssnf_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_rsp_if
// Response channel: eight segment codes and the reject flag.
// ----------------------------------------------------------------------------
interface ssnf_rsp_if
    import ssnf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SEGS_W-1:0] segments;
    logic              rejected;

    modport source (output valid, segments, rejected, input ready);
    modport sink   (input valid, segments, rejected, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ssnf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_front
// Input stage: sign split, range check and hex count cap, registered.
// ----------------------------------------------------------------------------
module ssnf_front
    import ssnf_pkg::*;
#(
    parameter int DIGITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic        i_op,
    input  wire logic [31:0] i_value_bits,
    input  wire logic [3:0]  i_dots,
    input  wire logic [3:0]  i_hex_count,
    output t_cell_st         o_st
);

    localparam logic [3:0] C_DIGITS = 4'(DIGITS);

    t_cell_st    r_st;
    t_cell_st    n_st;
    logic        neg;
    logic [31:0] mag;
    logic        out_rng;

    always_comb begin
        neg     = i_value_bits[31];
        mag     = neg ? (32'd0 - i_value_bits) : i_value_bits;
        out_rng = neg ? (mag > DEC_MIN_MAG) : (i_value_bits > DEC_MAX);

        n_st          = '0;
        n_st.valid    = i_valid;
        n_st.op       = i_op;
        n_st.dots     = i_dots;
        n_st.hex_cnt  = (i_hex_count > C_DIGITS) ? C_DIGITS : i_hex_count;
        n_st.neg      = neg;
        n_st.rejected = (i_op == OP_DEC) && out_rng;
        n_st.val      = (i_op == OP_HEX) ? i_value_bits : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

>>> hw/rtl/ssnf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_cell
// One digit position: peels the low digit off the running value, places its
// code and hands the remaining value to the next cell.
// ----------------------------------------------------------------------------
module ssnf_cell
    import ssnf_pkg::*;
#(
    parameter int DIGITS = 8,
    parameter int IDX    = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_cell_st i_st,
    output t_cell_st      o_st
);

    localparam int         POS     = DIGITS - 1 - IDX;
    localparam int         POS_M   = (IDX < DIGITS - 1) ? (DIGITS - 2 - IDX) : 0;
    localparam logic       HAS_M   = (IDX < DIGITS - 1);
    localparam logic [3:0] C_IDX   = 4'(IDX);

    t_cell_st    r_st;
    t_cell_st    n_st;
    logic [63:0] prod;
    logic [31:0] quo;
    logic [31:0] rem_w;
    logic [3:0]  rem;

    always_comb begin
        prod  = i_st.val * RECIP_10;
        quo   = {3'b000, prod[63:35]};
        rem_w = i_st.val - ({quo[28:0], 3'b000} + {quo[30:0], 1'b0});
        rem   = rem_w[3:0];

        n_st = i_st;
        if (i_st.op == OP_HEX) begin
            if (C_IDX < i_st.hex_cnt) begin
                n_st.segments[SEG_W*POS +: SEG_W] = seg_code(i_st.val[3:0]);
            end
            n_st.val = {4'h0, i_st.val[31:4]};
        end else if (!i_st.done && !i_st.rejected) begin
            n_st.segments[SEG_W*POS +: SEG_W] = seg_code(rem);
            n_st.val = quo;
            if (quo == 32'd0 && C_IDX >= i_st.dots) begin
                n_st.done = 1'b1;
                // sign sits just left of the last digit when room remains
                if (i_st.neg && HAS_M) begin
                    n_st.segments[SEG_W*POS_M +: SEG_W] = SEG_MINUS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

>>> hw/rtl/seven_segment_number_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Formats a 32-bit number into seven-segment digit codes, decimal or hex.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: op (decimal signed or hex), value_bits, dots
//   and hex_count. o_rsp returns segments (position p at bits 7p+6..7p,
//   position 0 leftmost) and rejected for each request, in order.
//   A request is taken when valid and ready are both high.
// Structure: one input stage, then one cell per digit position,
//   each with a divide-by-ten multiplier.
// Throughput: one request per cycle unless stalled; the row of cells is a
//   pipeline and a new request enters while earlier ones move along it.
// Stall: when the response is held off, the whole row holds and i_req.ready
//   drops only while the last cell has a response waiting.
// Reset: synchronous, active low; clears all stage valid flags, so no
//   response is pending afterwards.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter
    import ssnf_pkg::*;
#(
    parameter int DIGITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ssnf_req_if.sink    i_req,
    ssnf_rsp_if.source  o_rsp
);

    t_cell_st chain [DIGITS+1];
    logic     adv;

    // advance the row whenever the output slot is empty or being drained
    assign adv         = !chain[DIGITS].valid || o_rsp.ready;
    assign i_req.ready = adv;

    ssnf_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_valid      (i_req.valid),
        .i_op         (i_req.op),
        .i_value_bits (i_req.value_bits),
        .i_dots       (i_req.dots),
        .i_hex_count  (i_req.hex_count),
        .o_st         (chain[0])
    );

    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        ssnf_cell #(
            .DIGITS (DIGITS),
            .IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_st    (chain[g]),
            .o_st    (chain[g+1])
        );
    end

    assign o_rsp.valid    = chain[DIGITS].valid;
    assign o_rsp.segments = chain[DIGITS].segments;
    assign o_rsp.rejected = chain[DIGITS].rejected;

endmodule
`default_nettype wire
